### src/drt_pkg.sv
// ----------------------------------------------------------------------------
// Difficulty retarget package
// Shared widths, register indexes, reset values and status codes.
// ----------------------------------------------------------------------------
package drt_pkg;

  localparam int unsigned FRAC_BITS_DEF = 16;
  localparam int unsigned DIFF_W        = 64;
  localparam int unsigned WORD_W        = 32;
  localparam int unsigned CFG_IDX_W     = 3;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_TARGET_DURATION = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_TARGET_GAIN     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_STEP_FACTOR = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_NETWORK_FLOOR   = 3'd3;

  localparam logic [WORD_W-1:0] TARGET_DURATION_RST = 32'd60;
  localparam logic [WORD_W-1:0] TARGET_GAIN_RST     = 32'd65536;
  localparam logic [WORD_W-1:0] MAX_STEP_FACTOR_RST = 32'd131072;
  localparam logic [DIFF_W-1:0] NETWORK_FLOOR_RST   = 64'd1;

  typedef enum logic [1:0] {
    LIMIT_NONE = 2'd0,
    LIMIT_RISE = 2'd1,
    LIMIT_FALL = 2'd2
  } limit_status_e;

endpackage

### src/drt_div.sv
// ----------------------------------------------------------------------------
// Pipelined restoring divider
// One quotient bit per stage; takes a new dividend every cycle.
// ----------------------------------------------------------------------------
module drt_div #(
  parameter int unsigned DividendWidth = drt_pkg::DIFF_W + drt_pkg::FRAC_BITS_DEF
) (
  input  logic                        clk_i,
  input  logic [DividendWidth-1:0]    dividend_i,
  input  logic [drt_pkg::WORD_W-1:0]  divisor_i,
  output logic [DividendWidth-1:0]    quotient_o
);
  import drt_pkg::*;

  logic [WORD_W-1:0]        rem_q  [DividendWidth];
  logic [WORD_W-1:0]        dvs_q  [DividendWidth];
  logic [DividendWidth-1:0] rest_q [DividendWidth];

  for (genvar s = 0; s < DividendWidth; s++) begin : g_stage
    logic [WORD_W-1:0]        rem_in;
    logic [WORD_W-1:0]        dvs_in;
    logic [DividendWidth-1:0] rest_in;
    logic [WORD_W:0]          trial;
    logic [WORD_W:0]          diff;
    logic [WORD_W-1:0]        rem_d;
    logic                     qbit;

    if (s == 0) begin : g_first
      assign rem_in  = '0;
      assign dvs_in  = divisor_i;
      assign rest_in = dividend_i;
    end else begin : g_next
      assign rem_in  = rem_q[s-1];
      assign dvs_in  = dvs_q[s-1];
      assign rest_in = rest_q[s-1];
    end

    assign trial = {rem_in, rest_in[DividendWidth-1]};
    assign diff  = trial - {1'b0, dvs_in};

    always_comb begin
      qbit = (trial >= {1'b0, dvs_in});
      if (qbit) begin
        rem_d = diff[WORD_W-1:0];
      end else begin
        rem_d = trial[WORD_W-1:0];
      end
    end

    // Shift the consumed dividend bit out and the quotient bit in
    always_ff @(posedge clk_i) begin
      rem_q[s]  <= rem_d;
      dvs_q[s]  <= dvs_in;
      rest_q[s] <= {rest_in[DividendWidth-2:0], qbit};
    end
  end

  assign quotient_o = rest_q[DividendWidth-1];

endmodule

### src/difficulty_retarget_unit.sv
// ----------------------------------------------------------------------------
// Difficulty retarget unit
// Throughput: one request per cycle; busy_o stays low, the divider stages
// (one quotient bit each) set the depth. Results cannot be stalled.
// Reset clears all valid bits and loads the configuration reset values.
// ----------------------------------------------------------------------------
module difficulty_retarget_unit #(
  parameter int unsigned FACTOR_FRAC_BITS = drt_pkg::FRAC_BITS_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           start_i,
  output logic                           busy_o,
  input  logic [drt_pkg::DIFF_W-1:0]     prev_difficulty_i,
  input  logic signed [drt_pkg::WORD_W-1:0] block_duration_i,
  input  logic signed [drt_pkg::WORD_W-1:0] duration_correction_i,
  output logic                           done_o,
  output logic [drt_pkg::DIFF_W-1:0]     new_difficulty_o,
  output logic [1:0]                     limit_status_o,
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [drt_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [drt_pkg::DIFF_W-1:0]     cfg_data_i
);
  import drt_pkg::*;

  localparam int unsigned F       = FACTOR_FRAC_BITS;
  localparam int unsigned DivW    = DIFF_W + F;
  localparam int unsigned FacW    = 65 - F;
  localparam int unsigned Latency = DivW + 7;

  // Configuration
  logic [WORD_W-1:0] target_duration_q, target_gain_q, max_step_factor_q;
  logic [DIFF_W-1:0] network_floor_q;
  logic [63:0]       tprod_q;
  logic [WORD_W-1:0] mf_eff;

  assign cfg_ready_o = 1'b1;
  assign busy_o      = 1'b0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      target_duration_q <= TARGET_DURATION_RST;
      target_gain_q     <= TARGET_GAIN_RST;
      max_step_factor_q <= MAX_STEP_FACTOR_RST;
      network_floor_q   <= NETWORK_FLOOR_RST;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        REG_TARGET_DURATION: target_duration_q <= cfg_data_i[WORD_W-1:0];
        REG_TARGET_GAIN:     target_gain_q     <= cfg_data_i[WORD_W-1:0];
        REG_MAX_STEP_FACTOR: max_step_factor_q <= cfg_data_i[WORD_W-1:0];
        REG_NETWORK_FLOOR:   network_floor_q   <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    tprod_q <= 64'(target_duration_q) * 64'(target_gain_q);
  end

  assign mf_eff = (max_step_factor_q == '0) ? 32'd1 : max_step_factor_q;

  // Stage 0: input register, divisor from duration plus correction
  logic              v0_q;
  logic [DIFF_W-1:0] prev0_q;
  logic [WORD_W-1:0] corr0_q, dvs0_q;
  logic [WORD_W:0]   dsum;

  assign dsum = {block_duration_i[WORD_W-1], block_duration_i}
              + {duration_correction_i[WORD_W-1], duration_correction_i};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v0_q <= 1'b0;
    end else begin
      v0_q <= start_i && !busy_o;
    end
  end

  always_ff @(posedge clk_i) begin
    prev0_q <= prev_difficulty_i;
    corr0_q <= duration_correction_i;
    if (dsum[WORD_W] || dsum == '0) begin
      dvs0_q <= 32'd1;
    end else begin
      dvs0_q <= dsum[WORD_W-1:0];
    end
  end

  // Dividers: prev / sum and prev * 2^F / max factor
  logic [DivW-1:0] q1, q2;

  drt_div #(.DividendWidth(DivW)) u_div_dur (
    .clk_i     (clk_i),
    .dividend_i({{F{1'b0}}, prev0_q}),
    .divisor_i (dvs0_q),
    .quotient_o(q1)
  );

  drt_div #(.DividendWidth(DivW)) u_div_hold (
    .clk_i     (clk_i),
    .dividend_i({prev0_q, {F{1'b0}}}),
    .divisor_i (mf_eff),
    .quotient_o(q2)
  );

  // Sideband line alongside the divider stages
  logic              vl_q    [DivW];
  logic [DIFF_W-1:0] prevl_q [DivW];
  logic [WORD_W-1:0] corrl_q [DivW];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < DivW; i++) vl_q[i] <= 1'b0;
    end else begin
      vl_q[0] <= v0_q;
      for (int i = 1; i < DivW; i++) vl_q[i] <= vl_q[i-1];
    end
  end

  always_ff @(posedge clk_i) begin
    prevl_q[0] <= prev0_q;
    corrl_q[0] <= corr0_q;
    for (int i = 1; i < DivW; i++) begin
      prevl_q[i] <= prevl_q[i-1];
      corrl_q[i] <= corrl_q[i-1];
    end
  end

  // T1: floor quotient at 1, build target factor, saturate fall hold
  logic              v1_q;
  logic [DIFF_W-1:0] n1_q, prev1_q, hold1_q;
  logic [FacW-1:0]   fac1_q;
  logic [FacW:0]     fac_sum;

  assign fac_sum = {2'b00, tprod_q[63:F]}
                 + {{(FacW+1-WORD_W){corrl_q[DivW-1][WORD_W-1]}}, corrl_q[DivW-1]};

  always_ff @(posedge clk_i) begin
    n1_q    <= (q1[DIFF_W-1:0] == '0) ? 64'd1 : q1[DIFF_W-1:0];
    fac1_q  <= fac_sum[FacW] ? '0 : fac_sum[FacW-1:0];
    hold1_q <= (|q2[DivW-1:DIFF_W]) ? '1 : q2[DIFF_W-1:0];
    prev1_q <= prevl_q[DivW-1];
  end

  // T2: partial products
  logic              v2_q;
  logic [63:0]       pp00_q, pp01_q, pp10_q, pp11_q, pc0_q, pc1_q;
  logic [DIFF_W-1:0] prev2_q, hold2_q;
  logic [63:0]       fac64;

  assign fac64 = {{(64-FacW){1'b0}}, fac1_q};

  always_ff @(posedge clk_i) begin
    pp00_q  <= 64'(n1_q[31:0])  * 64'(fac64[31:0]);
    pp01_q  <= 64'(n1_q[31:0])  * 64'(fac64[63:32]);
    pp10_q  <= 64'(n1_q[63:32]) * 64'(fac64[31:0]);
    pp11_q  <= 64'(n1_q[63:32]) * 64'(fac64[63:32]);
    pc0_q   <= 64'(prev1_q[31:0])  * 64'(mf_eff);
    pc1_q   <= 64'(prev1_q[63:32]) * 64'(mf_eff);
    prev2_q <= prev1_q;
    hold2_q <= hold1_q;
  end

  // T3: middle sum and rise cap sum
  logic              v3_q;
  logic [64:0]       mid3_q;
  logic [95:0]       capsum3_q;
  logic [127:0]      lohi3_q;
  logic [DIFF_W-1:0] prev3_q, hold3_q;

  always_ff @(posedge clk_i) begin
    mid3_q    <= {1'b0, pp01_q} + {1'b0, pp10_q};
    capsum3_q <= {32'b0, pc0_q} + {pc1_q, 32'b0};
    lohi3_q   <= {pp11_q, pp00_q};
    prev3_q   <= prev2_q;
    hold3_q   <= hold2_q;
  end

  // T4: full product, saturated rise cap
  logic              v4_q;
  logic [127:0]      prod4_q;
  logic [DIFF_W-1:0] cap4_q, prev4_q, hold4_q;

  always_ff @(posedge clk_i) begin
    prod4_q <= lohi3_q + {31'b0, mid3_q, 32'b0};
    cap4_q  <= (|capsum3_q[95:64+F]) ? '1 : capsum3_q[63+F:F];
    prev4_q <= prev3_q;
    hold4_q <= hold3_q;
  end

  // T5: saturate product, apply network floor
  logic              v5_q;
  logic [DIFF_W-1:0] nd5_q, cap5_q, prev5_q, hold5_q;
  logic [DIFF_W-1:0] nd_sat;

  assign nd_sat = (|prod4_q[127:64]) ? '1 : prod4_q[63:0];

  always_ff @(posedge clk_i) begin
    nd5_q   <= (nd_sat < network_floor_q) ? network_floor_q : nd_sat;
    cap5_q  <= cap4_q;
    prev5_q <= prev4_q;
    hold5_q <= hold4_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q   <= 1'b0;
      v2_q   <= 1'b0;
      v3_q   <= 1'b0;
      v4_q   <= 1'b0;
      v5_q   <= 1'b0;
      done_o <= 1'b0;
    end else begin
      v1_q   <= vl_q[DivW-1];
      v2_q   <= v1_q;
      v3_q   <= v2_q;
      v4_q   <= v3_q;
      v5_q   <= v4_q;
      done_o <= v5_q;
    end
  end

  // T6: step limiting and output register
  logic [DIFF_W-1:0] nd_lim;
  limit_status_e     status;

  always_comb begin
    nd_lim = nd5_q;
    status = LIMIT_NONE;
    if (nd5_q > prev5_q) begin
      if (nd5_q > cap5_q) begin
        nd_lim = cap5_q;
        status = LIMIT_RISE;
      end
    end else if (nd5_q < hold5_q) begin
      nd_lim = hold5_q;
      status = LIMIT_FALL;
    end
  end

  always_ff @(posedge clk_i) begin
    new_difficulty_o <= (nd_lim == '0) ? 64'd1 : nd_lim;
    limit_status_o   <= status;
  end

  // Checks
  a_latency : assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i |-> ##Latency done_o) else $error("result missing after request");

  a_nonzero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> new_difficulty_o != '0) else $error("difficulty below one");

  a_status : assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> (limit_status_o == LIMIT_NONE || limit_status_o == LIMIT_RISE ||
                limit_status_o == LIMIT_FALL)) else $error("bad limit status");

endmodule
